// ===== rtl/owm_pkg.sv =====
// owm_pkg: shared types, codes and reset values for the one-wire bus master core
// used by owm_if, owm_csr and one_wire_bus_master_core; no dependencies

package owm_pkg;

   localparam int unsigned TIME_W  = 10;
   localparam int unsigned PULL_W  = 20;
   localparam int unsigned COUNT_W = 20;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned BIT_W   = 3;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;

   // command codes on the mode field
   localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RESET  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PULLUP = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESET_LOW     = 3'd0,
      CSR_PRES_SAMPLE   = 3'd1,
      CSR_PRES_RECOVERY = 3'd2,
      CSR_SLOT_START    = 3'd3,
      CSR_READ_SAMPLE   = 3'd4,
      CSR_READ_RECOVERY = 3'd5,
      CSR_WRITE_SLOT    = 3'd6,
      CSR_STRONG_PULLUP = 3'd7
   } csr_index_type;

   localparam logic [TIME_W-1:0] RST_RESET_LOW     = 10'd480;
   localparam logic [TIME_W-1:0] RST_PRES_SAMPLE   = 10'd60;
   localparam logic [TIME_W-1:0] RST_PRES_RECOVERY = 10'd420;
   localparam logic [TIME_W-1:0] RST_SLOT_START    = 10'd2;
   localparam logic [TIME_W-1:0] RST_READ_SAMPLE   = 10'd15;
   localparam logic [TIME_W-1:0] RST_READ_RECOVERY = 10'd50;
   localparam logic [TIME_W-1:0] RST_WRITE_SLOT    = 10'd120;
   localparam logic [PULL_W-1:0] RST_STRONG_PULLUP = 20'd750000;

   typedef struct packed {
      logic [TIME_W-1:0] reset_low_time;
      logic [TIME_W-1:0] presence_sample_time;
      logic [TIME_W-1:0] presence_recovery_time;
      logic [TIME_W-1:0] slot_start_time;
      logic [TIME_W-1:0] read_sample_delay;
      logic [TIME_W-1:0] read_recovery_time;
      logic [TIME_W-1:0] write_slot_time;
      logic [PULL_W-1:0] strong_pullup_time;
   } cfg_type;

   typedef enum logic [9:0] {
      PH_IDLE     = 10'b0000000001,
      PH_RST_LOW  = 10'b0000000010,
      PH_RST_WAIT = 10'b0000000100,
      PH_RST_REC  = 10'b0000001000,
      PH_WR_LOW   = 10'b0000010000,
      PH_WR_HOLD  = 10'b0000100000,
      PH_RD_LOW   = 10'b0001000000,
      PH_RD_WAIT  = 10'b0010000000,
      PH_RD_REC   = 10'b0100000000,
      PH_PULLUP   = 10'b1000000000
   } phase_type;

endpackage

// ===== rtl/owm_if.sv =====
// owm_if: request and response channel interfaces of the one-wire bus master core
// depends on owm_pkg for field widths

interface owm_req_if;
   logic                           valid;
   logic                           ready;
   logic [owm_pkg::MODE_W-1:0]     mode;
   logic [owm_pkg::BYTE_W-1:0]     data_byte;
   logic                           line_level;

   modport source (output valid, output mode, output data_byte, output line_level,
                   input ready);
   modport sink   (input valid, input mode, input data_byte, input line_level,
                   output ready);
endinterface

interface owm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           drive_low;
   logic                           drive_high;
   logic                           busy_res;
   logic                           done_res;
   logic [owm_pkg::BYTE_W-1:0]     read_data;
   logic                           no_presence;
   logic                           rejected;

   modport source (output valid, output drive_low, output drive_high, output busy_res,
                   output done_res, output read_data, output no_presence,
                   output rejected, input ready);
   modport sink   (input valid, input drive_low, input drive_high, input busy_res,
                   input done_res, input read_data, input no_presence,
                   input rejected, output ready);
endinterface

// ===== rtl/owm_csr.sv =====
// owm_csr: timing register bank of the one-wire bus master core
// depends on owm_pkg for widths, register indexes and reset values

module owm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [owm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [owm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output owm_pkg::cfg_type                  cfg
);

   owm_pkg::cfg_type cfg_ff;
   logic [owm_pkg::TIME_W-1:0] wdata_short;

   assign wdata_short = csr_wdata[owm_pkg::TIME_W-1:0];
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time         <= owm_pkg::RST_RESET_LOW;
         cfg_ff.presence_sample_time   <= owm_pkg::RST_PRES_SAMPLE;
         cfg_ff.presence_recovery_time <= owm_pkg::RST_PRES_RECOVERY;
         cfg_ff.slot_start_time        <= owm_pkg::RST_SLOT_START;
         cfg_ff.read_sample_delay      <= owm_pkg::RST_READ_SAMPLE;
         cfg_ff.read_recovery_time     <= owm_pkg::RST_READ_RECOVERY;
         cfg_ff.write_slot_time        <= owm_pkg::RST_WRITE_SLOT;
         cfg_ff.strong_pullup_time     <= owm_pkg::RST_STRONG_PULLUP;
      end else if (csr_we) begin
         unique case (owm_pkg::csr_index_type'(csr_index))
            owm_pkg::CSR_RESET_LOW:     cfg_ff.reset_low_time         <= wdata_short;
            owm_pkg::CSR_PRES_SAMPLE:   cfg_ff.presence_sample_time   <= wdata_short;
            owm_pkg::CSR_PRES_RECOVERY: cfg_ff.presence_recovery_time <= wdata_short;
            owm_pkg::CSR_SLOT_START:    cfg_ff.slot_start_time        <= wdata_short;
            owm_pkg::CSR_READ_SAMPLE:   cfg_ff.read_sample_delay      <= wdata_short;
            owm_pkg::CSR_READ_RECOVERY: cfg_ff.read_recovery_time     <= wdata_short;
            owm_pkg::CSR_WRITE_SLOT:    cfg_ff.write_slot_time        <= wdata_short;
            owm_pkg::CSR_STRONG_PULLUP: cfg_ff.strong_pullup_time     <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/one_wire_bus_master_core.sv =====
// one_wire_bus_master_core: top level of the one-wire bus master, one tick per transaction
// depends on owm_pkg, owm_if (owm_req_if, owm_rsp_if) and owm_csr
//
//   channel   direction   handshake        carries
//   req_ch    in          valid/ready      mode, data_byte, line_level
//   rsp_ch    out         valid/ready      drive_low, drive_high, busy_res, done_res,
//                                          read_data, no_presence, rejected
//   csr_*     in          csr_we           csr_index, csr_wdata (no read-back)
//
// each request transaction is one bus tick; its response is registered and
// appears the cycle after acceptance, one transaction per cycle sustained while rsp_ch.ready is high
// the phase/counter update and the output register are fed by the same combinational logic
// req_ch.ready stays high while the response register is empty or being drained
// reset is synchronous: phase idle, counters, read data, presence and response valid cleared, timing registers preset

module one_wire_bus_master_core (
   input  logic                              clock,
   input  logic                              reset,
   owm_req_if.sink                           req_ch,
   owm_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [owm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [owm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   owm_pkg::cfg_type cfg;

   owm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owm_pkg::phase_type                 phase_ff, phase_in, phase_cur;
   logic [owm_pkg::COUNT_W-1:0]        tick_count_ff, tick_count_in, tick_cur, tick_inc;
   logic [owm_pkg::BIT_W-1:0]          bit_index_ff, bit_index_in, bit_cur;
   logic [owm_pkg::BYTE_W-1:0]         shift_byte_ff, shift_byte_in, shift_cur;
   logic [owm_pkg::BYTE_W-1:0]         last_read_ff, last_read_in;
   logic                               presence_ff, presence_in;

   logic                               rsp_valid_ff;
   logic                               drive_low_ff, drive_high_ff, busy_ff, done_ff;
   logic                               rejected_ff;
   logic                               dl, dh, done, rej, hit, wr_bit;
   logic [owm_pkg::COUNT_W-1:0]        dur, eff;
   logic                               req_fire;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // command start, then one tick of the resulting phase
   always_comb begin
      phase_cur = phase_ff;
      tick_cur  = tick_count_ff;
      bit_cur   = bit_index_ff;
      shift_cur = shift_byte_ff;
      rej       = 1'b0;
      case (req_ch.mode) inside
         owm_pkg::MODE_RESET, owm_pkg::MODE_WRITE, owm_pkg::MODE_READ,
         owm_pkg::MODE_PULLUP: begin
            if (phase_ff != owm_pkg::PH_IDLE) begin
               rej = 1'b1;
            end else begin
               tick_cur = '0;
               bit_cur  = '0;
               case (req_ch.mode)
                  owm_pkg::MODE_RESET: phase_cur = owm_pkg::PH_RST_LOW;
                  owm_pkg::MODE_WRITE: begin
                     shift_cur = req_ch.data_byte;
                     phase_cur = owm_pkg::PH_WR_LOW;
                  end
                  owm_pkg::MODE_READ: begin
                     shift_cur = '0;
                     phase_cur = owm_pkg::PH_RD_LOW;
                  end
                  default: phase_cur = owm_pkg::PH_PULLUP;
               endcase
            end
         end
         default: ;
      endcase

      unique case (phase_cur)
         owm_pkg::PH_RST_LOW:  dur = owm_pkg::COUNT_W'(cfg.reset_low_time);
         owm_pkg::PH_RST_WAIT: dur = owm_pkg::COUNT_W'(cfg.presence_sample_time);
         owm_pkg::PH_RST_REC:  dur = owm_pkg::COUNT_W'(cfg.presence_recovery_time);
         owm_pkg::PH_WR_LOW,
         owm_pkg::PH_RD_LOW:   dur = owm_pkg::COUNT_W'(cfg.slot_start_time);
         owm_pkg::PH_WR_HOLD:  dur = owm_pkg::COUNT_W'(cfg.write_slot_time);
         owm_pkg::PH_RD_WAIT:  dur = owm_pkg::COUNT_W'(cfg.read_sample_delay);
         owm_pkg::PH_RD_REC:   dur = owm_pkg::COUNT_W'(cfg.read_recovery_time);
         owm_pkg::PH_PULLUP:   dur = cfg.strong_pullup_time;
         default:              dur = '0;
      endcase
      // a zero duration counts as one tick
      eff      = (dur == '0) ? owm_pkg::COUNT_W'(1) : dur;
      tick_inc = tick_cur + owm_pkg::COUNT_W'(1);
      hit      = (tick_inc >= eff);
      wr_bit   = shift_cur[bit_cur];

      phase_in      = phase_cur;
      tick_count_in = hit ? '0 : tick_inc;
      bit_index_in  = bit_cur;
      shift_byte_in = shift_cur;
      last_read_in  = last_read_ff;
      presence_in   = presence_ff;
      dl            = 1'b0;
      dh            = 1'b0;
      done          = 1'b0;

      unique case (phase_cur)
         owm_pkg::PH_RST_LOW: begin
            dl = 1'b1;
            if (hit) phase_in = owm_pkg::PH_RST_WAIT;
         end
         owm_pkg::PH_RST_WAIT: begin
            if (hit) begin
               if (req_ch.line_level) begin
                  presence_in = 1'b1;
                  done        = 1'b1;
               end else begin
                  presence_in = 1'b0;
                  if (cfg.presence_recovery_time == '0) done = 1'b1;
                  else phase_in = owm_pkg::PH_RST_REC;
               end
            end
         end
         owm_pkg::PH_RST_REC: begin
            if (hit) done = 1'b1;
         end
         owm_pkg::PH_WR_LOW: begin
            dl = 1'b1;
            if (hit) phase_in = owm_pkg::PH_WR_HOLD;
         end
         owm_pkg::PH_WR_HOLD: begin
            dh = wr_bit;
            dl = !wr_bit;
            if (hit) begin
               if (bit_cur == '1) begin
                  done = 1'b1;
               end else begin
                  bit_index_in = bit_cur + owm_pkg::BIT_W'(1);
                  phase_in     = owm_pkg::PH_WR_LOW;
               end
            end
         end
         owm_pkg::PH_RD_LOW: begin
            dl = 1'b1;
            if (hit) phase_in = owm_pkg::PH_RD_WAIT;
         end
         owm_pkg::PH_RD_WAIT: begin
            if (hit) begin
               shift_byte_in[bit_cur] = shift_cur[bit_cur] | req_ch.line_level;
               if (cfg.read_recovery_time != '0) begin
                  phase_in = owm_pkg::PH_RD_REC;
               end else if (bit_cur == '1) begin
                  last_read_in = shift_byte_in;
                  done         = 1'b1;
               end else begin
                  bit_index_in = bit_cur + owm_pkg::BIT_W'(1);
                  phase_in     = owm_pkg::PH_RD_LOW;
               end
            end
         end
         owm_pkg::PH_RD_REC: begin
            if (hit) begin
               if (bit_cur == '1) begin
                  last_read_in = shift_cur;
                  done         = 1'b1;
               end else begin
                  bit_index_in = bit_cur + owm_pkg::BIT_W'(1);
                  phase_in     = owm_pkg::PH_RD_LOW;
               end
            end
         end
         owm_pkg::PH_PULLUP: begin
            dh = 1'b1;
            if (hit) done = 1'b1;
         end
         default: begin
            // idle: counter holds
            phase_in      = owm_pkg::PH_IDLE;
            tick_count_in = tick_cur;
         end
      endcase

      if (done) begin
         phase_in      = owm_pkg::PH_IDLE;
         tick_count_in = '0;
         bit_index_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= owm_pkg::PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff  <= '0;
         shift_byte_ff <= '0;
         last_read_ff  <= '0;
         presence_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff      <= phase_in;
            tick_count_ff <= tick_count_in;
            bit_index_ff  <= bit_index_in;
            shift_byte_ff <= shift_byte_in;
            last_read_ff  <= last_read_in;
            presence_ff   <= presence_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         drive_low_ff  <= dl;
         drive_high_ff <= dh;
         busy_ff       <= (phase_in != owm_pkg::PH_IDLE);
         done_ff       <= done;
         rejected_ff   <= rej;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.drive_low   = drive_low_ff;
   assign rsp_ch.drive_high  = drive_high_ff;
   assign rsp_ch.busy_res    = busy_ff;
   assign rsp_ch.done_res    = done_ff;
   assign rsp_ch.read_data   = last_read_ff;
   assign rsp_ch.no_presence = presence_ff;
   assign rsp_ch.rejected    = rejected_ff;

   a_drive_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(drive_low_ff && drive_high_ff))
      else $error("bus driven low and high in the same tick");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> !busy_ff)
      else $error("finished command still reported busy");

   a_reject_in_command: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rejected_ff) |-> (busy_ff || done_ff))
      else $error("command rejected while no command was running");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == owm_pkg::PH_IDLE) |-> (bit_index_ff == '0 && tick_count_ff == '0))
      else $error("idle phase with stale slot counters");

endmodule
